### rtl/xce_pkg.sv
// Shared types, escape sequence codes and sequence tables for the XML context escaper.
package xce_pkg;

  typedef logic [2:0] seq_code_t;
  typedef logic [2:0] seq_idx_t;

  localparam seq_code_t SEQ_NONE = 3'd0;
  localparam seq_code_t SEQ_AMP  = 3'd1;
  localparam seq_code_t SEQ_LT   = 3'd2;
  localparam seq_code_t SEQ_GT   = 3'd3;
  localparam seq_code_t SEQ_QUOT = 3'd4;
  localparam seq_code_t SEQ_TAB  = 3'd5;
  localparam seq_code_t SEQ_LF   = 3'd6;
  localparam seq_code_t SEQ_CR   = 3'd7;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_QUOT    = 8'h22;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;

  typedef struct packed {
    seq_code_t  code;
    logic [7:0] raw;
  } item_t;

  typedef struct packed {
    logic      busy;
    seq_code_t code;
    seq_idx_t  idx;
  } emit_status_t;

  function automatic seq_idx_t seq_len(input seq_code_t code);
    seq_idx_t len;
    case (code)
      SEQ_NONE: len = 3'd1;
      SEQ_AMP:  len = 3'd5;
      SEQ_LT:   len = 3'd4;
      SEQ_GT:   len = 3'd4;
      SEQ_QUOT: len = 3'd6;
      SEQ_TAB:  len = 3'd4;
      SEQ_LF:   len = 3'd5;
      SEQ_CR:   len = 3'd5;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] seq_char(input seq_code_t code, input seq_idx_t idx,
                                          input logic [7:0] raw);
    logic [7:0] ch;
    ch = CH_AMP;
    case (code)
      SEQ_NONE: ch = raw;
      SEQ_AMP: begin
        case (idx)
          3'd1:    ch = "a";
          3'd2:    ch = "m";
          3'd3:    ch = "p";
          3'd4:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_LT: begin
        case (idx)
          3'd1:    ch = "l";
          3'd2:    ch = "t";
          3'd3:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_GT: begin
        case (idx)
          3'd1:    ch = "g";
          3'd2:    ch = "t";
          3'd3:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_QUOT: begin
        case (idx)
          3'd1:    ch = "q";
          3'd2:    ch = "u";
          3'd3:    ch = "o";
          3'd4:    ch = "t";
          3'd5:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_TAB: begin
        case (idx)
          3'd1:    ch = "#";
          3'd2:    ch = "9";
          3'd3:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_LF: begin
        case (idx)
          3'd1:    ch = "#";
          3'd2:    ch = "1";
          3'd3:    ch = "0";
          3'd4:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      SEQ_CR: begin
        case (idx)
          3'd1:    ch = "#";
          3'd2:    ch = "1";
          3'd3:    ch = "3";
          3'd4:    ch = ";";
          default: ch = CH_AMP;
        endcase
      end
      default: ch = raw;
    endcase
    return ch;
  endfunction

endpackage

### rtl/xce_classify.sv
// Byte classifier: picks the escape sequence and tracks the trailing ']' count.
module xce_classify (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              context_req,
  input  logic              first_of_string,
  output xce_pkg::item_t    item
);

  logic [1:0] bracket_run_r;
  logic [1:0] bracket_run_nxt;
  logic [1:0] run;

  assign run = first_of_string ? 2'd0 : bracket_run_r;

  always_comb begin
    item.raw  = in_byte;
    item.code = xce_pkg::SEQ_NONE;
    if (context_req) begin
      case (in_byte)
        xce_pkg::CH_AMP:  item.code = xce_pkg::SEQ_AMP;
        xce_pkg::CH_LT:   item.code = xce_pkg::SEQ_LT;
        xce_pkg::CH_QUOT: item.code = xce_pkg::SEQ_QUOT;
        xce_pkg::CH_TAB:  item.code = xce_pkg::SEQ_TAB;
        xce_pkg::CH_LF:   item.code = xce_pkg::SEQ_LF;
        xce_pkg::CH_CR:   item.code = xce_pkg::SEQ_CR;
        default:          item.code = xce_pkg::SEQ_NONE;
      endcase
    end else begin
      if (in_byte == xce_pkg::CH_AMP) begin
        item.code = xce_pkg::SEQ_AMP;
      end else if (in_byte == xce_pkg::CH_LT) begin
        item.code = xce_pkg::SEQ_LT;
      end else if (in_byte == xce_pkg::CH_GT && run[1]) begin
        item.code = xce_pkg::SEQ_GT;
      end
    end
  end

  always_comb begin
    bracket_run_nxt = bracket_run_r;
    if (fire) begin
      if (in_byte == xce_pkg::CH_RBRACK) begin
        bracket_run_nxt = (run == 2'd3) ? 2'd3 : run + 2'd1;
      end else begin
        bracket_run_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bracket_run_r <= 2'd0;
    end else begin
      bracket_run_r <= bracket_run_nxt;
    end
  end

endmodule

### rtl/xce_emit.sv
// Sequence emitter: holds one classified byte and steps out its escape run.
module xce_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_valid,
  output logic                    load_ready,
  input  xce_pkg::item_t          load_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output xce_pkg::emit_status_t   status
);

  logic              s1_valid_r, s1_valid_nxt;
  xce_pkg::item_t    s1_item_r, s1_item_nxt;
  xce_pkg::seq_idx_t idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic out_load;
  logic emit_now;
  logic cur_last;

  assign out_load   = !out_valid_r || out_ready;
  assign emit_now   = s1_valid_r && out_load;
  assign cur_last   = (idx_r == xce_pkg::seq_len(s1_item_r.code) - 3'd1);
  assign load_ready = !s1_valid_r || (emit_now && cur_last);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    idx_nxt      = idx_r;
    if (load_valid && load_ready) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = load_item;
      idx_nxt      = 3'd0;
    end else if (emit_now && cur_last) begin
      s1_valid_nxt = 1'b0;
    end else if (emit_now) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
      out_byte_nxt  = xce_pkg::seq_char(s1_item_r.code, idx_r, s1_item_r.raw);
      out_last_nxt  = cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;
  assign status.busy = s1_valid_r;
  assign status.code = s1_item_r.code;
  assign status.idx  = idx_r;

endmodule

### rtl/xml_context_escaper_core.sv
// XML context escaper top level: classifier, emitter and checks.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  input    | in_valid / in_ready    | in_byte, in_context_req, in_first_of_string
//  result   | out_valid / out_ready  | out_byte, out_last_of_run
//
// Plain text that passes through streams at one byte per clock while out_ready is high.
// An escaped byte holds the emitter until its sequence (4 to 6 bytes) is out; the single
// hold register takes no new byte before then. Bytes pass hold, then result register.
// Reset (rst_n low, synchronous) empties both stages and clears the ']' count.
// out_ready low freezes a valid result register; an empty hold register still takes a byte.
module xml_context_escaper_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_context_req,
  input  logic       in_first_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  xce_pkg::item_t        item;
  xce_pkg::emit_status_t status;
  logic                  in_fire;

  assign in_fire = in_valid && in_ready;

  xce_classify u_classify (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .in_byte         (in_byte),
    .context_req     (in_context_req),
    .first_of_string (in_first_of_string),
    .item            (item)
  );

  xce_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid),
    .load_ready (in_ready),
    .load_item  (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last_of_run),
    .status     (status)
  );

  a_first_gt_plain: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_first_of_string && !in_context_req && in_byte == xce_pkg::CH_GT
    |-> item.code == xce_pkg::SEQ_NONE)
    else $error("'>' at string start escaped");

  a_attr_quot: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_context_req && in_byte == xce_pkg::CH_QUOT
    |-> item.code == xce_pkg::SEQ_QUOT)
    else $error("attribute quote not escaped");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> status.idx < xce_pkg::seq_len(status.code))
    else $error("emitter index past sequence end");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy && status.code != xce_pkg::SEQ_NONE && status.idx == 3'd0 |-> !in_ready)
    else $error("input accepted while escape run pending");

endmodule
